### src/mmx_pkg.sv
// ----------------------------------------------------------------------------
// mmx_pkg
// Shared types, codes and widths for the modulation matrix evaluator.
// ----------------------------------------------------------------------------
package mmx_pkg;

  localparam int NUM_SOURCES      = 9;
  localparam int NUM_DESTS        = 7;
  localparam int NUM_ROUTE_REGS   = 8;
  localparam int ROUTE_COUNT_DEF  = 8;
  localparam int CFG_W            = 25;
  localparam int CFG_IDX_W        = 3;
  localparam int LEVEL_W          = 16;
  localparam int DEPTH_W          = 16;
  localparam int DEST_W           = 3;
  localparam int OUT_W            = 24;
  localparam int TERM_W           = 31;
  localparam int NUM_STAGES       = 6;
  localparam int OUT_MAX          = 8388607;
  localparam int OUT_MIN          = -8388608;

  typedef enum logic [3:0] {
    SRC_NONE       = 4'd0,
    SRC_LFO1       = 4'd1,
    SRC_LFO2       = 4'd2,
    SRC_ENV1       = 4'd3,
    SRC_ENV2       = 4'd4,
    SRC_VELOCITY   = 4'd5,
    SRC_KBD_TRACK  = 4'd6,
    SRC_WHEEL_POS  = 4'd7,
    SRC_BEND_POS   = 4'd8,
    SRC_AFTERTOUCH = 4'd9
  } src_code_t;

  typedef enum logic [DEST_W-1:0] {
    DEST_PITCH     = 3'd0,
    DEST_CUTOFF    = 3'd1,
    DEST_AMP       = 3'd2,
    DEST_RESONANCE = 3'd3,
    DEST_SUB_LEVEL = 3'd4,
    DEST_NOISE     = 3'd5,
    DEST_PWM       = 3'd6
  } dest_code_t;

  typedef enum logic [1:0] {
    CURVE_LINEAR = 2'd0,
    CURVE_SQUARE = 2'd1,
    CURVE_CUBE   = 2'd2
  } curve_code_t;

  // same bit layout as the route register
  typedef struct packed {
    logic signed [DEPTH_W-1:0] depth;
    logic [1:0]                curve;
    logic [DEST_W-1:0]         dst;
    logic [3:0]                src;
  } route_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
  } pipe_ctrl_t;

  typedef logic [NUM_SOURCES-1:0][LEVEL_W-1:0] src_vec_t;
  typedef logic [NUM_DESTS-1:0][OUT_W-1:0]     sum_vec_t;

endpackage

### src/mmx_src_if.sv
// ----------------------------------------------------------------------------
// mmx_src_if
// Input channel: one snapshot of the nine modulation source levels.
// ----------------------------------------------------------------------------
interface mmx_src_if import mmx_pkg::*; ;
  logic                      valid;
  logic                      ready;
  logic signed [LEVEL_W-1:0] lfo1;
  logic signed [LEVEL_W-1:0] lfo2;
  logic signed [LEVEL_W-1:0] env1;
  logic signed [LEVEL_W-1:0] env2;
  logic signed [LEVEL_W-1:0] velocity;
  logic signed [LEVEL_W-1:0] kbd_track;
  logic signed [LEVEL_W-1:0] wheel_pos;
  logic signed [LEVEL_W-1:0] bend_pos;
  logic signed [LEVEL_W-1:0] aftertouch;

  modport source (
    output valid, lfo1, lfo2, env1, env2, velocity, kbd_track, wheel_pos,
           bend_pos, aftertouch,
    input  ready
  );
  modport sink (
    input  valid, lfo1, lfo2, env1, env2, velocity, kbd_track, wheel_pos,
           bend_pos, aftertouch,
    output ready
  );
endinterface

### src/mmx_res_if.sv
// ----------------------------------------------------------------------------
// mmx_res_if
// Result channel: the seven saturated destination sums.
// ----------------------------------------------------------------------------
interface mmx_res_if import mmx_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] pitch_mod;
  logic signed [OUT_W-1:0] filter_mod;
  logic signed [OUT_W-1:0] amp_mod;
  logic signed [OUT_W-1:0] resonance_mod;
  logic signed [OUT_W-1:0] sub_level_mod;
  logic signed [OUT_W-1:0] noise_level_mod;
  logic signed [OUT_W-1:0] pwm_mod;

  modport source (
    output valid, pitch_mod, filter_mod, amp_mod, resonance_mod, sub_level_mod,
           noise_level_mod, pwm_mod,
    input  ready
  );
  modport sink (
    input  valid, pitch_mod, filter_mod, amp_mod, resonance_mod, sub_level_mod,
           noise_level_mod, pwm_mod,
    output ready
  );
endinterface

### src/modulation_matrix_eval_unit.sv
// ----------------------------------------------------------------------------
// modulation_matrix_eval_unit
// Modulation matrix: eight routes scaled, shaped and summed into seven sums.
// ----------------------------------------------------------------------------
// six register stages lie between input accept and result valid
// one item per cycle while the output is not stalled, all routes evaluated in parallel lanes
// stage depth is set by the cube path (two chained multiplies per lane)
// a stage holds only while the stage after it is full and stalled
// reset (rst_n low, synchronous) empties the pipeline and clears all routes
module modulation_matrix_eval_unit import mmx_pkg::*; #(
  parameter int ROUTE_COUNT = ROUTE_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  mmx_src_if.sink              in_if,
  mmx_res_if.source            out_if
);

  // route registers
  route_t [ROUTE_COUNT-1:0] route_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      route_r <= '0;
    end else if (cfg_we) begin
      for (int i = 0; i < ROUTE_COUNT; i++) begin
        if (cfg_index == CFG_IDX_W'(i)) begin
          route_r[i] <= route_t'(cfg_data);
        end
      end
    end
  end

  // valid chain and per-stage enables
  logic [NUM_STAGES-1:0] v_r;
  logic [NUM_STAGES-1:0] v_nxt;
  pipe_ctrl_t            ctrl;

  always_comb begin
    ctrl.en[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || out_if.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      ctrl.en[k] = !v_r[k] || ctrl.en[k+1];
    end
    v_nxt[0] = ctrl.en[0] ? in_if.valid : v_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      v_nxt[k] = ctrl.en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_if.ready  = ctrl.en[0];
  assign out_if.valid = v_r[NUM_STAGES-1];

  src_vec_t levels;
  assign levels[0] = in_if.lfo1;
  assign levels[1] = in_if.lfo2;
  assign levels[2] = in_if.env1;
  assign levels[3] = in_if.env2;
  assign levels[4] = in_if.velocity;
  assign levels[5] = in_if.kbd_track;
  assign levels[6] = in_if.wheel_pos;
  assign levels[7] = in_if.bend_pos;
  assign levels[8] = in_if.aftertouch;

  logic [ROUTE_COUNT-1:0][TERM_W-1:0] terms;
  logic [ROUTE_COUNT-1:0][DEST_W-1:0] dsts;

  for (genvar g = 0; g < ROUTE_COUNT; g++) begin : g_lane
    mmx_route_lane u_lane (
      .clk    (clk),
      .ctrl   (ctrl),
      .route  (route_r[g]),
      .levels (levels),
      .term   (terms[g])
    );
    assign dsts[g] = route_r[g].dst;
  end

  sum_vec_t sums;

  mmx_dest_sum #(
    .ROUTE_COUNT (ROUTE_COUNT)
  ) u_sum (
    .clk   (clk),
    .ctrl  (ctrl),
    .terms (terms),
    .dsts  (dsts),
    .sums  (sums)
  );

  assign out_if.pitch_mod       = sums[DEST_PITCH];
  assign out_if.filter_mod      = sums[DEST_CUTOFF];
  assign out_if.amp_mod         = sums[DEST_AMP];
  assign out_if.resonance_mod   = sums[DEST_RESONANCE];
  assign out_if.sub_level_mod   = sums[DEST_SUB_LEVEL];
  assign out_if.noise_level_mod = sums[DEST_NOISE];
  assign out_if.pwm_mod         = sums[DEST_PWM];

  // the input side only stalls when a full pipeline meets a stalled output
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> (out_if.valid && !out_if.ready))
    else $error("input stalled without output backpressure");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> v_r[0])
    else $error("accepted item did not enter first stage");

  a_idle_routes_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && (route_r == '0)) |->
      (out_if.pitch_mod == '0 && out_if.filter_mod == '0 && out_if.amp_mod == '0
       && out_if.resonance_mod == '0 && out_if.sub_level_mod == '0
       && out_if.noise_level_mod == '0 && out_if.pwm_mod == '0))
    else $error("nonzero sum with all routes inactive");

endmodule

### src/mmx_route_lane.sv
// ----------------------------------------------------------------------------
// mmx_route_lane
// One route: source select, depth multiply and curve shaping, four stages.
// ----------------------------------------------------------------------------
module mmx_route_lane import mmx_pkg::*; (
  input  logic                     clk,
  input  pipe_ctrl_t               ctrl,
  input  route_t                   route,
  input  src_vec_t                 levels,
  output logic signed [TERM_W-1:0] term
);

  // stage 1: level times depth, Q.23
  logic signed [LEVEL_W-1:0] level;
  logic signed [31:0]        p_nxt;
  logic signed [31:0]        p_r;

  always_comb begin
    unique case (route.src)
      SRC_LFO1:       level = $signed(levels[0]);
      SRC_LFO2:       level = $signed(levels[1]);
      SRC_ENV1:       level = $signed(levels[2]);
      SRC_ENV2:       level = $signed(levels[3]);
      SRC_VELOCITY:   level = $signed(levels[4]);
      SRC_KBD_TRACK:  level = $signed(levels[5]);
      SRC_WHEEL_POS:  level = $signed(levels[6]);
      SRC_BEND_POS:   level = $signed(levels[7]);
      SRC_AFTERTOUCH: level = $signed(levels[8]);
      default:        level = '0;
    endcase
    p_nxt = level * route.depth;
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      p_r <= p_nxt;
    end
  end

  // stage 2: linear rounding, p*|p| and c*c for the cube
  logic signed [32:0] p_ext;
  logic signed [32:0] lin_full;
  logic signed [32:0] c_full;
  logic signed [31:0] mag;
  logic signed [63:0] sqr_prod;
  logic signed [23:0] c_nxt;
  logic signed [47:0] cc_prod;
  logic signed [16:0] lin2_r;
  logic signed [61:0] sqr_r;
  logic signed [23:0] c_r;
  logic signed [45:0] cc_r;

  always_comb begin
    p_ext    = $signed({p_r[31], p_r});
    lin_full = p_ext + 33'sd16384;
    c_full   = p_ext + 33'sd128;
    c_nxt    = c_full[31:8];
    mag      = p_r[31] ? -p_r : p_r;
    sqr_prod = p_r * mag;
    cc_prod  = c_nxt * c_nxt;
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[1]) begin
      lin2_r <= lin_full[31:15];
      sqr_r  <= sqr_prod[61:0];
      c_r    <= c_nxt;
      cc_r   <= cc_prod[45:0];
    end
  end

  // stage 3: round square, round c*c and multiply by c again
  logic signed [46:0] sq_full;
  logic signed [30:0] sq;
  logic signed [54:0] cube_prod;
  logic signed [62:0] sqt_full;
  logic signed [16:0] lin3_r;
  logic signed [23:0] sqt3_r;
  logic signed [54:0] cube_r;

  always_comb begin
    sq_full   = $signed({cc_r[45], cc_r}) + 47'sd16384;
    sq        = sq_full[45:15];
    cube_prod = sq * c_r;
    sqt_full  = $signed({sqr_r[61], sqr_r}) + (63'sd1 <<< 37);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[2]) begin
      lin3_r <= lin2_r;
      sqt3_r <= sqt_full[61:38];
      cube_r <= cube_prod;
    end
  end

  // stage 4: round the cube, pick the curve, zero inactive routes
  logic signed [55:0]       cub_full;
  logic signed [TERM_W-1:0] shaped;
  logic                     active;
  logic signed [TERM_W-1:0] term_nxt;
  logic signed [TERM_W-1:0] term_r;

  always_comb begin
    cub_full = $signed({cube_r[54], cube_r}) + (56'sd1 <<< 21);
    unique case (route.curve)
      CURVE_SQUARE: shaped = TERM_W'(sqt3_r);
      CURVE_CUBE:   shaped = cub_full[52:22];
      default:      shaped = TERM_W'(lin3_r);
    endcase
    active   = (route.src != SRC_NONE) && (route.depth != '0)
               && (int'(route.dst) < NUM_DESTS);
    term_nxt = active ? shaped : '0;
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[3]) begin
      term_r <= term_nxt;
    end
  end

  assign term = term_r;

endmodule

### src/mmx_dest_sum.sv
// ----------------------------------------------------------------------------
// mmx_dest_sum
// Per-destination adder tree over the route terms, then saturation.
// ----------------------------------------------------------------------------
module mmx_dest_sum import mmx_pkg::*; #(
  parameter int ROUTE_COUNT = ROUTE_COUNT_DEF
) (
  input  logic                                  clk,
  input  pipe_ctrl_t                            ctrl,
  input  logic [ROUTE_COUNT-1:0][TERM_W-1:0]    terms,
  input  logic [ROUTE_COUNT-1:0][DEST_W-1:0]    dsts,
  output sum_vec_t                              sums
);

  localparam int PART_COUNT = (ROUTE_COUNT + 1) / 2;
  localparam int PART_W     = TERM_W + 1;
  localparam int SUM_W      = PART_W + 2;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(OUT_MAX);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(OUT_MIN);

  // stage 5: pairs of routes per destination
  logic signed [PART_W-1:0] part_nxt [NUM_DESTS][PART_COUNT];
  logic signed [PART_W-1:0] part_r   [NUM_DESTS][PART_COUNT];

  always_comb begin
    for (int d = 0; d < NUM_DESTS; d++) begin
      for (int k = 0; k < PART_COUNT; k++) begin
        part_nxt[d][k] = '0;
      end
      for (int i = 0; i < ROUTE_COUNT; i++) begin
        if (dsts[i] == DEST_W'(d)) begin
          part_nxt[d][i >> 1] = part_nxt[d][i >> 1] + PART_W'($signed(terms[i]));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[4]) begin
      part_r <= part_nxt;
    end
  end

  // stage 6: final add and clamp to Q16.8
  logic signed [SUM_W-1:0] total [NUM_DESTS];
  sum_vec_t                sums_nxt;
  sum_vec_t                sums_r;

  always_comb begin
    for (int d = 0; d < NUM_DESTS; d++) begin
      total[d] = '0;
      for (int k = 0; k < PART_COUNT; k++) begin
        total[d] = total[d] + SUM_W'(part_r[d][k]);
      end
      if (total[d] > SAT_HI) begin
        sums_nxt[d] = SAT_HI[OUT_W-1:0];
      end else if (total[d] < SAT_LO) begin
        sums_nxt[d] = SAT_LO[OUT_W-1:0];
      end else begin
        sums_nxt[d] = total[d][OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[5]) begin
      sums_r <= sums_nxt;
    end
  end

  assign sums = sums_r;

endmodule
